### design/s256fa_pkg.sv
// Package for the secp256k1 field ALU: operation codes, field constants, exponents.
// No dependencies.
package s256fa_pkg;

	typedef enum logic [2:0] {
		FN_MUL  = 3'd0,
		FN_SQR  = 3'd1,
		FN_ADD  = 3'd2,
		FN_NEG  = 3'd3,
		FN_INV  = 3'd4,
		FN_SQRT = 3'd5,
		FN_RED  = 3'd6,
		FN_RSV  = 3'd7
	} func_t;

	localparam logic [255:0] PRIME =
		256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
	localparam logic [255:0] INV_EXP =
		256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2D;
	localparam logic [255:0] SQRT_EXP =
		256'h3FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_BFFFFF0C;
	// 2^256 mod p
	localparam logic [32:0] FOLD_K = 33'h1000003D1;
	// low part of FOLD_K; the 2^32 part is a one-limb shift
	localparam logic [31:0] FOLD_C = 32'd977;

endpackage

### design/s256fa_mul.sv
// Iterative 256x256 modular multiplier on one shared 32x32 multiplier: 64 limb
// products, three limb-serial folding passes by 2^256 mod p, final subtract. Uses s256fa_pkg.
module s256fa_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] x,
	input  logic [255:0] y,
	output logic         done,
	output logic [255:0] prod
);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_FOLD = 4'b0100,
		M_FIN  = 4'b1000
	} mstate_t;

	mstate_t      state_q;
	logic [2:0]   row_q;
	logic [2:0]   col_q;
	logic [3:0]   limb_q;
	logic [1:0]   pass_q;
	logic [31:0]  carry_q;
	logic [511:0] acc_q;
	logic [255:0] x_q;
	logic [255:0] y_q;

	logic [3:0]   wi;
	logic [3:0]   hi_idx;
	logic [3:0]   hip_idx;
	logic [31:0]  acc_limb;
	logic [31:0]  lo_limb;
	logic [31:0]  hi_limb;
	logic [31:0]  hip_limb;
	logic [31:0]  mop_a;
	logic [31:0]  mop_b;
	logic [63:0]  mprod;
	logic [63:0]  step_sum;
	logic [511:0] acc_nx;
	logic [256:0] sub;

	// product step: limb row_q of x times limb col_q of y into limb row_q + col_q
	assign wi       = {1'b0, row_q} + {1'b0, col_q};
	assign acc_limb = acc_q[{wi, 5'd0} +: 32];

	// fold step on limb i: lo[i] + hi[i]*977 + hi[i-1] + carry
	assign hi_idx   = limb_q + 4'd8;
	assign hip_idx  = limb_q + 4'd7;
	assign lo_limb  = (limb_q < 4'd8) ? acc_q[{limb_q, 5'd0} +: 32] : 32'd0;
	assign hi_limb  = (limb_q < 4'd8) ? acc_q[{hi_idx, 5'd0} +: 32] : 32'd0;
	assign hip_limb = (limb_q != 4'd0) ? acc_q[{hip_idx, 5'd0} +: 32] : 32'd0;

	assign mop_a = (state_q == M_MUL) ? x_q[{row_q, 5'd0} +: 32] : hi_limb;
	assign mop_b = (state_q == M_MUL) ? y_q[{col_q, 5'd0} +: 32] : s256fa_pkg::FOLD_C;
	assign mprod = {32'd0, mop_a} * {32'd0, mop_b};

	assign step_sum = (state_q == M_MUL)
		? mprod + {32'd0, acc_limb} + {32'd0, carry_q}
		: mprod + {32'd0, lo_limb} + {32'd0, hip_limb} + {32'd0, carry_q};

	always_comb begin
		acc_nx = acc_q;
		if (state_q == M_MUL) begin
			acc_nx[{wi, 5'd0} +: 32] = step_sum[31:0];
			if (col_q == 3'd7)
				acc_nx[{wi + 4'd1, 5'd0} +: 32] = step_sum[63:32];
		end else if (state_q == M_FOLD) begin
			acc_nx[{limb_q, 5'd0} +: 32] = step_sum[31:0];
			// last step of a pass: carry lands in limb 9, limbs above are consumed
			if (limb_q == 4'd8)
				acc_nx[511:288] = {192'd0, step_sum[63:32]};
		end
	end

	assign sub  = {1'b0, acc_q[255:0]} - {1'b0, s256fa_pkg::PRIME};
	assign prod = acc_q[255:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			limb_q  <= '0;
			pass_q  <= '0;
			carry_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= (state_q == M_FIN);
			unique case (state_q)
				M_IDLE: if (start) begin
					state_q <= M_MUL;
					row_q   <= '0;
					col_q   <= '0;
					carry_q <= '0;
				end
				M_MUL: begin
					col_q <= col_q + 3'd1;
					if (col_q != 3'd7) begin
						carry_q <= step_sum[63:32];
					end else begin
						carry_q <= '0;
						row_q   <= row_q + 3'd1;
						if (row_q == 3'd7) begin
							state_q <= M_FOLD;
							limb_q  <= '0;
							pass_q  <= '0;
						end
					end
				end
				M_FOLD: begin
					if (limb_q != 4'd8) begin
						limb_q  <= limb_q + 4'd1;
						carry_q <= step_sum[63:32];
					end else begin
						limb_q  <= '0;
						carry_q <= '0;
						pass_q  <= pass_q + 2'd1;
						if (pass_q == 2'd2) state_q <= M_FIN;
					end
				end
				M_FIN: state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			M_IDLE: if (start) begin
				x_q   <= x;
				y_q   <= y;
				acc_q <= '0;
			end
			M_MUL:  acc_q <= acc_nx;
			M_FOLD: acc_q <= acc_nx;
			M_FIN: if (!sub[256]) acc_q <= {256'd0, sub[255:0]};
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == M_FIN)) else $error("done without final step");
	a_prod_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> prod < s256fa_pkg::PRIME) else $error("product not reduced");
`endif

endmodule

### design/secp256k1_field_alu_top.sv
// Top level of the secp256k1 field ALU: sequencer around the shared multiplier.
// Depends on s256fa_pkg and s256fa_mul.
//
// Use: present func and operands a, b with in_valid; the beat is taken when
// in_valid is high and in_stall is low. in_stall stays high from the accept
// until the result beat is taken. The result beat (res_word0..3, is_zero,
// is_odd) is shown with out_valid and held while out_stall is high.
// Add, negate and reduce pass through operand reduce and one op step. Multiply
// and square run one multiplier pass: 64 limb products on a 32x32 multiplier,
// 27 fold steps, a final subtract and a done handoff. Inverse and square root run
// square-and-multiply over 256 exponent bits, one multiplier pass per square or
// multiply.
// One item at a time: the next beat can be taken in the cycle after the result
// beat is taken. A stalled result holds the whole block.
// Reset empties the block; the first item can be taken right after.
module secp256k1_field_alu_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [63:0] a_word0,
	input  logic [63:0] a_word1,
	input  logic [63:0] a_word2,
	input  logic [63:0] a_word3,
	input  logic [63:0] b_word0,
	input  logic [63:0] b_word1,
	input  logic [63:0] b_word2,
	input  logic [63:0] b_word3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] res_word0,
	output logic [63:0] res_word1,
	output logic [63:0] res_word2,
	output logic [63:0] res_word3,
	output logic        is_zero,
	output logic        is_odd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RED   = 7'b0000010,
		S_OP    = 7'b0000100,
		S_MWAIT = 7'b0001000,
		S_PSQ   = 7'b0010000,
		S_PMUL  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t              state_q;
	s256fa_pkg::func_t   func_q;
	logic [255:0]        a_q, b_q, r_q;
	logic [7:0]          bit_q;
	logic                mstart;
	logic [255:0]        mx, my, mprod;
	logic                mdone;

	s256fa_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart),
		.x(mx), .y(my), .done(mdone), .prod(mprod)
	);

	// one conditional subtract fully reduces any 256-bit value
	function automatic logic [255:0] red1(input logic [255:0] v);
		logic [256:0] d;
		d = {1'b0, v} - {1'b0, s256fa_pkg::PRIME};
		red1 = d[256] ? v : d[255:0];
	endfunction

	logic [256:0] sum;
	logic [255:0] neg;
	logic         ebit;
	assign sum  = {1'b0, a_q} + {1'b0, b_q};
	assign neg  = (a_q == '0) ? '0 : s256fa_pkg::PRIME - a_q;
	assign ebit = (func_q == s256fa_pkg::FN_INV) ? s256fa_pkg::INV_EXP[bit_q]
		: s256fa_pkg::SQRT_EXP[bit_q];

	always_comb begin
		mstart = 1'b0;
		mx     = r_q;
		my     = r_q;
		unique case (state_q)
			S_OP: begin
				mx = a_q;
				my = (func_q == s256fa_pkg::FN_MUL) ? b_q : a_q;
				mstart = (func_q == s256fa_pkg::FN_MUL) || (func_q == s256fa_pkg::FN_SQR)
					|| (func_q == s256fa_pkg::FN_INV) || (func_q == s256fa_pkg::FN_SQRT);
				if ((func_q == s256fa_pkg::FN_INV) || (func_q == s256fa_pkg::FN_SQRT)) begin
					mx = 256'd1;
					my = 256'd1;
				end
			end
			S_PSQ: mstart = 1'b1;
			S_PMUL: begin
				mstart = 1'b1;
				my     = a_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign res_word0 = r_q[63:0];
	assign res_word1 = r_q[127:64];
	assign res_word2 = r_q[191:128];
	assign res_word3 = r_q[255:192];
	assign is_zero   = (r_q == '0);
	assign is_odd    = r_q[0];

	// pow phase flag: set while the multiply by a for the current bit runs
	logic pmul_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RED;
				S_RED:  state_q <= S_OP;
				S_OP: begin
					if (mstart) state_q <= S_MWAIT;
					else state_q <= S_OUT;
				end
				S_MWAIT: if (mdone) begin
					if ((func_q == s256fa_pkg::FN_MUL) || (func_q == s256fa_pkg::FN_SQR))
						state_q <= S_OUT;
					else if (!pmul_q && ebit)
						state_q <= S_PMUL;
					else if (bit_q == 8'd0)
						state_q <= S_OUT;
					else
						state_q <= S_PSQ;
				end
				S_PSQ:  state_q <= S_MWAIT;
				S_PMUL: state_q <= S_MWAIT;
				S_OUT:  if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				func_q <= s256fa_pkg::func_t'(func);
				a_q    <= {a_word3, a_word2, a_word1, a_word0};
				b_q    <= {b_word3, b_word2, b_word1, b_word0};
			end
			S_RED: begin
				a_q <= red1(a_q);
				b_q <= red1(b_q);
			end
			S_OP: begin
				bit_q  <= 8'd255;
				pmul_q <= 1'b0;
				case (func_q) inside
					s256fa_pkg::FN_ADD: r_q <= sum[256] ? sum[255:0] + {223'd0, s256fa_pkg::FOLD_K}
						: red1(sum[255:0]);
					s256fa_pkg::FN_NEG: r_q <= neg;
					s256fa_pkg::FN_RED, s256fa_pkg::FN_RSV: r_q <= a_q;
					default: ;
				endcase
			end
			S_MWAIT: if (mdone) begin
				r_q <= mprod;
				if ((func_q == s256fa_pkg::FN_INV) || (func_q == s256fa_pkg::FN_SQRT))
					pmul_q <= !pmul_q && ebit;
			end
			S_PSQ:  bit_q <= bit_q - 8'd1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(r_q)) else $error("result lost");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result waits");
	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> r_q < s256fa_pkg::PRIME) else $error("result not reduced");
`endif

endmodule

### tb/tb.sv
// Testbench for secp256k1_field_alu_top: directed and random field operations,
// checked against a behavioral prime-field predictor with random idling on both sides.
// Depends on s256fa_pkg and the block's RTL.
module tb;

	localparam int NUM_RAND = 750;
	localparam int WDOG_LIMIT = 400000;

	typedef struct packed {
		s256fa_pkg::func_t fn;
		logic [255:0]      a;
		logic [255:0]      b;
	} op_beat_t;

	typedef struct packed {
		logic [255:0] r;
		logic         zero;
		logic         odd;
	} field_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] func = '0;
	logic [63:0] a_word0 = '0, a_word1 = '0, a_word2 = '0, a_word3 = '0;
	logic [63:0] b_word0 = '0, b_word1 = '0, b_word2 = '0, b_word3 = '0;
	logic out_valid;
	logic out_stall = 1;
	logic [63:0] res_word0, res_word1, res_word2, res_word3;
	logic is_zero, is_odd;

	op_beat_t pending_ops[$];
	field_res_t expected_res[$];
	int errors = 0;
	int idle_phase = 0;
	int watchdog = 0;

	secp256k1_field_alu_top u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [255:0] mod_p(logic [511:0] x);
		logic [511:0] m;
		m = x % {256'd0, s256fa_pkg::PRIME};
		return m[255:0];
	endfunction

	function automatic logic [255:0] mul_mod(logic [255:0] x, logic [255:0] y);
		return mod_p({256'd0, x} * {256'd0, y});
	endfunction

	function automatic logic [255:0] pow_mod(logic [255:0] x, logic [255:0] e);
		logic [255:0] acc;
		acc = 256'd1;
		for (int i = 255; i >= 0; i--) begin
			acc = mul_mod(acc, acc);
			if (e[i])
				acc = mul_mod(acc, x);
		end
		return acc;
	endfunction

	function automatic field_res_t predict_field_op(op_beat_t op);
		field_res_t res;
		logic [255:0] ar, br;
		ar = mod_p({256'd0, op.a});
		br = mod_p({256'd0, op.b});
		case (op.fn)
			s256fa_pkg::FN_MUL:  res.r = mul_mod(ar, br);
			s256fa_pkg::FN_SQR:  res.r = mul_mod(ar, ar);
			s256fa_pkg::FN_ADD:  res.r = mod_p({256'd0, ar} + {256'd0, br});
			s256fa_pkg::FN_NEG:  res.r = (ar == 0) ? '0 : s256fa_pkg::PRIME - ar;
			s256fa_pkg::FN_INV:  res.r = pow_mod(ar, s256fa_pkg::INV_EXP);
			s256fa_pkg::FN_SQRT: res.r = pow_mod(ar, s256fa_pkg::SQRT_EXP);
			default: res.r = ar;
		endcase
		res.zero = (res.r == 0);
		res.odd = res.r[0];
		return res;
	endfunction

	function automatic logic [255:0] rand_word256();
		logic [255:0] v;
		for (int i = 0; i < 8; i++)
			v[i*32 +: 32] = $urandom;
		return v;
	endfunction

	// Biased operand: mostly random, sometimes near 0, near p, or near 2^256.
	function automatic logic [255:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 256'($urandom_range(0, 3));
			1: return s256fa_pkg::PRIME - 256'($urandom_range(0, 3));
			2: return s256fa_pkg::PRIME + 256'($urandom_range(0, 'h3D0));
			3: return '1 - 256'($urandom_range(0, 3));
			default: return rand_word256();
		endcase
	endfunction

	task automatic add_op(s256fa_pkg::func_t fn, logic [255:0] a, logic [255:0] b);
		op_beat_t op;
		op.fn = fn;
		op.a = a;
		op.b = b;
		pending_ops.push_back(op);
	endtask

	task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// Driver: holds the current beat until it is taken.
	always @(posedge clk) begin
		int gap_pct;
		op_beat_t op;
		gap_pct = (idle_phase == 0) ? 19 : (idle_phase == 1) ? 68 : 0;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (in_valid)
				expected_res.push_back(predict_field_op({s256fa_pkg::func_t'(func),
					{a_word3, a_word2, a_word1, a_word0},
					{b_word3, b_word2, b_word1, b_word0}}));
			if (pending_ops.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
				op = pending_ops.pop_front();
				in_valid <= 1;
				func <= op.fn;
				{a_word3, a_word2, a_word1, a_word0} <= op.a;
				{b_word3, b_word2, b_word1, b_word0} <= op.b;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction.
	always @(posedge clk) begin
		int stall_pct;
		field_res_t want;
		stall_pct = (idle_phase == 0) ? 68 : (idle_phase == 1) ? 19 : 0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected beat",
						{res_word3, res_word2, res_word1, res_word0}, '0);
				end else begin
					want = expected_res.pop_front();
					if ({res_word3, res_word2, res_word1, res_word0} != want.r)
						report_mismatch("result",
							{res_word3, res_word2, res_word1, res_word0}, want.r);
					if (is_zero != want.zero)
						report_mismatch("is_zero", 256'(is_zero), 256'(want.zero));
					if (is_odd != want.odd)
						report_mismatch("is_odd", 256'(is_odd), 256'(want.odd));
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog: sized for inverse and square root, which hold the input longest.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		s256fa_pkg::func_t fn;
		int f;
		int g;
		add_op(s256fa_pkg::FN_MUL, '0, '1);
		add_op(s256fa_pkg::FN_MUL, '1, '1);
		add_op(s256fa_pkg::FN_MUL, s256fa_pkg::PRIME - 1, s256fa_pkg::PRIME - 1);
		add_op(s256fa_pkg::FN_SQR, s256fa_pkg::PRIME, '0);
		add_op(s256fa_pkg::FN_SQR, '1, '0);
		add_op(s256fa_pkg::FN_ADD, s256fa_pkg::PRIME - 1, s256fa_pkg::PRIME - 1);
		add_op(s256fa_pkg::FN_ADD, '1, '1);
		add_op(s256fa_pkg::FN_ADD, s256fa_pkg::PRIME - 1, 256'd1);
		add_op(s256fa_pkg::FN_NEG, '0, '1);
		add_op(s256fa_pkg::FN_NEG, s256fa_pkg::PRIME, '0);
		add_op(s256fa_pkg::FN_NEG, 256'd1, '0);
		add_op(s256fa_pkg::FN_INV, '0, '0);
		add_op(s256fa_pkg::FN_INV, 256'd2, '1);
		add_op(s256fa_pkg::FN_SQRT, 256'd4, '0);
		add_op(s256fa_pkg::FN_SQRT, s256fa_pkg::PRIME - 1, '0);
		add_op(s256fa_pkg::FN_RED, '1, '1);
		add_op(s256fa_pkg::FN_RED, s256fa_pkg::PRIME, '0);
		add_op(s256fa_pkg::FN_RED, s256fa_pkg::PRIME - 1, '0);
		add_op(s256fa_pkg::FN_RSV, '1, '0);
		add_op(s256fa_pkg::FN_RSV, 256'd5, '1);
		for (int i = 0; i < NUM_RAND; i++) begin
			// inverse and square root are slow; keep them rare
			f = $urandom_range(0, 99);
			if (f < 2) begin
				fn = s256fa_pkg::FN_INV;
			end else if (f < 4) begin
				fn = s256fa_pkg::FN_SQRT;
			end else begin
				// the six fast codes: mul, square, add, negate, reduce, unused
				g = $urandom_range(0, 5);
				fn = s256fa_pkg::func_t'(3'((g >= 4) ? g + 2 : g));
			end
			add_op(fn, rand_operand(), rand_operand());
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;
		wait (pending_ops.size() <= 500);
		idle_phase = 1;
		wait (pending_ops.size() <= 250);
		idle_phase = 2;
		wait (pending_ops.size() == 0 && !(in_valid && in_stall) && in_valid == 0);
		wait (expected_res.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
